### rtl/mrtt_pkg.sv
// package with command codes and register indexes of the multi-rate task trigger timer
package mrtt_pkg;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_START   = 2'd1,
      CMD_ACK     = 2'd2,
      CMD_SERVICE = 2'd3
   } cmd_type;

   localparam logic [2:0] CSR_FAST_DIV    = 3'd0;
   localparam logic [2:0] CSR_SLOW_DIV    = 3'd1;
   localparam logic [2:0] CSR_FAST_COUNT  = 3'd2;
   localparam logic [2:0] CSR_SLOW_COUNT  = 3'd3;
   localparam logic [2:0] CSR_FAST_START  = 3'd4;
   localparam logic [2:0] CSR_FAST_PERIOD = 3'd5;
   localparam logic [2:0] CSR_SLOW_START  = 3'd6;
   localparam logic [2:0] CSR_SLOW_PERIOD = 3'd7;

   localparam logic [7:0] START_SATURATE = 8'd255;

   function automatic logic [15:0] start_load(input logic [7:0] v);
      logic [15:0] r;
      r = (v == START_SATURATE) ? 16'd255 : {8'd0, v} + 16'd1;
      return r;
   endfunction

endpackage

### rtl/multi_rate_task_trigger_timer.sv
// top level of the multi-rate task trigger timer
//
// req channel: one command word per accepted transfer (tick, start, acknowledge
// fast task, service slow tick) with a task id used by acknowledge.
// rsp channel: exactly one word per command: fast pending mask, slow pending
// flag, slow due mask and an ignored flag, all as left by that command.
// csr port: single-cycle writes of the eight configuration registers.
// latency: the response word is valid the cycle after the command is accepted.
// throughput: one command per cycle; all counters update in parallel in the
// cycle of acceptance, the response register is the only pipeline stage.
// req_ready is high outside reset whenever the response register is empty or
// being taken, so a stalled receiver holds rsp_* and blocks only new commands.
// reset (synchronous): all counters, prescalers and pending bits clear, the
// dividers load 1, the other csr registers 0; the response register empties.
module multi_rate_task_trigger_timer #(
   parameter int FAST_TASKS = 8,
   parameter int SLOW_TASKS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_task_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_fast_pending,
   output logic        rsp_slow_pending,
   output logic [3:0]  rsp_slow_due,
   output logic        rsp_ignored,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [15:0] fast_div_ff, slow_div_ff;
   logic [3:0]  fast_count_ff;
   logic [2:0]  slow_count_ff;
   logic [63:0] fast_start_ff, fast_period_ff, slow_period_ff;
   logic [31:0] slow_start_ff;

   logic [15:0] fast_pre_ff, fast_pre_in;
   logic [15:0] slow_pre_ff, slow_pre_in;
   logic [15:0] fast_cnt_ff [FAST_TASKS];
   logic [15:0] fast_cnt_in [FAST_TASKS];
   logic [15:0] slow_cnt_ff [SLOW_TASKS];
   logic [15:0] slow_cnt_in [SLOW_TASKS];
   logic [FAST_TASKS-1:0] fast_pend_ff, fast_pend_in;
   logic slow_pend_ff, slow_pend_in;
   logic [SLOW_TASKS-1:0] due_in;
   logic ign_in;

   logic rsp_valid_ff;
   logic [7:0] rsp_fast_ff;
   logic rsp_slow_ff, rsp_ign_ff;
   logic [3:0] rsp_due_ff;

   logic accept;
   logic [3:0] nf;
   logic [2:0] ns;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign nf = (fast_count_ff > 4'(FAST_TASKS)) ? 4'(FAST_TASKS) : fast_count_ff;
   assign ns = (slow_count_ff > 3'(SLOW_TASKS)) ? 3'(SLOW_TASKS) : slow_count_ff;

   always_comb begin
      logic        fstep;
      logic [15:0] fdec, sdec, cdec, per;
      logic        hit;
      fast_pre_in  = fast_pre_ff;
      slow_pre_in  = slow_pre_ff;
      fast_cnt_in  = fast_cnt_ff;
      slow_cnt_in  = slow_cnt_ff;
      fast_pend_in = fast_pend_ff;
      slow_pend_in = slow_pend_ff;
      due_in       = '0;
      ign_in       = 1'b0;
      fstep        = 1'b0;
      fdec         = fast_pre_ff - 16'd1;
      sdec         = slow_pre_ff - 16'd1;
      cdec         = '0;
      per          = '0;
      hit          = 1'b0;
      unique case (mrtt_pkg::cmd_type'(req_command))
         mrtt_pkg::CMD_TICK: begin
            if (fast_div_ff > 16'd1) begin
               fast_pre_in = fdec;
               if (fdec == 16'd0) begin
                  fast_pre_in = fast_div_ff;
                  fstep       = 1'b1;
               end
            end else begin
               fstep = 1'b1;
            end
            if (fstep) begin
               for (int i = 0; i < FAST_TASKS; i++) begin
                  if (4'(i) < nf) begin
                     cdec = fast_cnt_ff[i] - 16'd1;
                     fast_cnt_in[i] = cdec;
                     if (cdec == 16'd0) fast_pend_in[i] = 1'b1;
                  end
               end
            end
            if (slow_div_ff > 16'd1) begin
               slow_pre_in = sdec;
               if (sdec == 16'd0) slow_pend_in = 1'b1;
            end else begin
               slow_pend_in = 1'b1;
            end
         end
         mrtt_pkg::CMD_START: begin
            fast_pend_in = '0;
            slow_pend_in = 1'b0;
            fast_pre_in  = 16'd1;
            slow_pre_in  = 16'd1;
            for (int i = 0; i < FAST_TASKS; i++) begin
               if (4'(i) < nf) fast_cnt_in[i] = mrtt_pkg::start_load(fast_start_ff[8*i +: 8]);
            end
            for (int i = 0; i < SLOW_TASKS; i++) begin
               if (3'(i) < ns) slow_cnt_in[i] = mrtt_pkg::start_load(slow_start_ff[8*i +: 8]);
            end
         end
         mrtt_pkg::CMD_ACK: begin
            for (int i = 0; i < FAST_TASKS; i++) begin
               if (3'(i) == req_task_id && 4'(i) < nf && fast_pend_ff[i]) hit = 1'b1;
            end
            ign_in = !hit;
            for (int i = 0; i < FAST_TASKS; i++) begin
               if (hit && 3'(i) == req_task_id) begin
                  per = {8'd0, fast_period_ff[8*i +: 8]};
                  fast_cnt_in[i]  = (per == 16'd0) ? 16'd1 : per;
                  fast_pend_in[i] = 1'b0;
               end
            end
         end
         mrtt_pkg::CMD_SERVICE: begin
            if (!slow_pend_ff) begin
               ign_in = 1'b1;
            end else begin
               slow_pre_in  = slow_div_ff;
               slow_pend_in = 1'b0;
               for (int i = 0; i < SLOW_TASKS; i++) begin
                  if (3'(i) < ns) begin
                     cdec = slow_cnt_ff[i] - 16'd1;
                     slow_cnt_in[i] = cdec;
                     if (cdec == 16'd0) begin
                        per = slow_period_ff[16*i +: 16];
                        slow_cnt_in[i] = (per == 16'd0) ? 16'd1 : per;
                        due_in[i] = 1'b1;
                     end
                  end
               end
            end
         end
         default: ign_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_div_ff    <= 16'd1;
         slow_div_ff    <= 16'd1;
         fast_count_ff  <= '0;
         slow_count_ff  <= '0;
         fast_start_ff  <= '0;
         fast_period_ff <= '0;
         slow_start_ff  <= '0;
         slow_period_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mrtt_pkg::CSR_FAST_DIV:    fast_div_ff    <= csr_data[15:0];
            mrtt_pkg::CSR_SLOW_DIV:    slow_div_ff    <= csr_data[15:0];
            mrtt_pkg::CSR_FAST_COUNT:  fast_count_ff  <= csr_data[3:0];
            mrtt_pkg::CSR_SLOW_COUNT:  slow_count_ff  <= csr_data[2:0];
            mrtt_pkg::CSR_FAST_START:  fast_start_ff  <= csr_data;
            mrtt_pkg::CSR_FAST_PERIOD: fast_period_ff <= csr_data;
            mrtt_pkg::CSR_SLOW_START:  slow_start_ff  <= csr_data[31:0];
            mrtt_pkg::CSR_SLOW_PERIOD: slow_period_ff <= csr_data;
            default:                   fast_div_ff    <= fast_div_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_pre_ff  <= '0;
         slow_pre_ff  <= '0;
         fast_pend_ff <= '0;
         slow_pend_ff <= 1'b0;
         for (int i = 0; i < FAST_TASKS; i++) fast_cnt_ff[i] <= '0;
         for (int i = 0; i < SLOW_TASKS; i++) slow_cnt_ff[i] <= '0;
      end else if (accept) begin
         fast_pre_ff  <= fast_pre_in;
         slow_pre_ff  <= slow_pre_in;
         fast_pend_ff <= fast_pend_in;
         slow_pend_ff <= slow_pend_in;
         fast_cnt_ff  <= fast_cnt_in;
         slow_cnt_ff  <= slow_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_fast_ff <= 8'(fast_pend_in);
         rsp_slow_ff <= slow_pend_in;
         rsp_due_ff  <= 4'(due_in);
         rsp_ign_ff  <= ign_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fast_pending = rsp_fast_ff;
   assign rsp_slow_pending = rsp_slow_ff;
   assign rsp_slow_due     = rsp_due_ff;
   assign rsp_ignored      = rsp_ign_ff;

endmodule

### rtl/mrtt_checker.sv
// port checker for the multi-rate task trigger timer and its bind
module mrtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_fast_pending,
   input logic        rsp_slow_pending,
   input logic [3:0]  rsp_slow_due,
   input logic        rsp_ignored
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fast_pending)
         && $stable(rsp_slow_due) && $stable(rsp_ignored))
      else $error("stalled response word changed");

   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word produced no response");

   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == mrtt_pkg::CMD_START
      |=> rsp_fast_pending == 8'd0 && !rsp_slow_pending && !rsp_ignored)
      else $error("start left pending bits set");

   a_due_service: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command != mrtt_pkg::CMD_SERVICE
      |=> rsp_slow_due == 4'd0)
      else $error("slow due reported outside a service");

endmodule

bind multi_rate_task_trigger_timer mrtt_checker u_mrtt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_command      (req_command),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_fast_pending (rsp_fast_pending),
   .rsp_slow_pending (rsp_slow_pending),
   .rsp_slow_due     (rsp_slow_due),
   .rsp_ignored      (rsp_ignored)
);
